// ===== src/ppcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcs_pkg
// Shared types and constants of the pattern push command sequencer: item
// structs, function and command codes, push phases, controller links.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcs_pkg;

  // Commands per tick burst
  localparam int unsigned PACKETS_PER_TICK = 6;
  localparam int unsigned BUDGET_W         = $clog2(PACKETS_PER_TICK + 1);

  // Grid geometry
  localparam int unsigned TRACKS  = 16;
  localparam int unsigned STEPS   = 16;
  localparam int unsigned POS_W   = 9;
  localparam logic [7:0]  PACING_RESET = 8'd2;

  // Input function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ARM  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Command kinds
  localparam logic [1:0] KIND_SELECT = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SELECT,
    PH_CLEAR,
    PH_ACTIVE,
    PH_START
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  row;
    logic [15:0] row_bits;
    logic [3:0]  slot;
    logic        link_up;
    logic        playing;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] sel_slot;
    logic [3:0] track;
    logic [3:0] step;
    logic       active;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // consume the input item
    logic step;    // run one step of the burst
    logic finish;  // close the burst, set the next burst time
    logic flush;   // push the held command out as the last of the burst
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go;       // the offered item is a tick that starts a burst
    logic done;     // budget spent or push idle
    logic pend_v;   // a command is held back
    logic out_free; // output register can take a command this cycle
  } dp_stat_t;

endpackage : ppcs_pkg

`default_nettype wire

// ===== src/pattern_push_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// pattern_push_command_sequencer_core
// Pushes a 16 x 16 step grid to a remote player as paced command bursts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : load a grid row, arm a push, or tick with the current ms time.
//           The block takes one item at a time; in_stall is high while a
//           tick burst runs. Load, arm and ignored items never stall.
//   out_* : one item per command; last marks the final command of a burst.
//   cfg_* : pacing interval in ms, always ready; write only while idle.
// Burst steps:
//   A tick that starts a burst is accepted, then each step issues a select,
//   clear, set or start command, or scans the rest of a grid row without a
//   hit at no budget cost. The burst then closes and flushes its last command.
// Stalls:
//   A stalled output holds its command; burst steps wait while another
//   command is held behind it, and in_stall stays high until the burst drains.
// Reset:
//   Synchronous, active low: push idle, grid cleared, pacing interval 2 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_push_command_sequencer_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ppcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ppcs_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);
  import ppcs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule : pattern_push_command_sequencer_core

`default_nettype wire

// ===== src/ppcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppcs_ctrl
// Controller: takes items while idle, runs a tick burst step by step, then
// closes the burst and flushes the held command with its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ppcs_pkg::dp_stat_t stat,
  output ppcs_pkg::dp_cmd_t       cmd
);
  import ppcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  // Sequence idle, burst and flush
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.go) begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (stat.done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_FLUSH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!stat.pend_v || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule : ppcs_ctrl

`default_nettype wire

// ===== src/ppcs_dp.sv =====
// ----------------------------------------------------------------------------
// ppcs_dp
// Datapath: step grid, push position and phase, burst budget, pacing time,
// one held command and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcs_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ppcs_pkg::in_item_t  in_data,
  input  wire ppcs_pkg::dp_cmd_t   cmd,
  output ppcs_pkg::dp_stat_t       stat,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ppcs_pkg::out_item_t      out_data
);
  import ppcs_pkg::*;

  // Lowest set bit: {found, index}
  function automatic logic [4:0] first_set(input logic [STEPS-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = STEPS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  logic [STEPS-1:0]    grid_r [TRACKS];
  logic [STEPS-1:0]    grid_nxt [TRACKS];
  phase_t              phase_r, phase_nxt;
  logic [3:0]          slot_r, slot_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [31:0]         next_time_r, next_time_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [7:0]          pacing_r;
  logic [31:0]         now_r;
  logic                playing_r;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                out_v_r, out_v_nxt;
  out_item_t           out_r, out_nxt;

  logic [3:0]          cur_t;
  logic [3:0]          cur_s;
  logic [STEPS-1:0]    scan_bits;
  logic [4:0]          hit;
  logic [31:0]         time_lag;
  logic                early;
  logic                out_free;
  logic                fire;
  logic                emit;
  out_item_t           cmd_item;

  assign cur_t     = pos_r[7:4];
  assign cur_s     = pos_r[3:0];
  assign scan_bits = grid_r[cur_t] & (16'hFFFF << cur_s);
  assign hit       = first_set(scan_bits);

  // Wrapping distance to the next burst time; negative means early
  assign time_lag  = in_data.now_ms - next_time_r;
  assign early     = time_lag[31];
  assign out_free  = !out_v_r || !out_stall;
  assign fire      = cmd.step && (!pend_v_r || out_free);

  // Status to the controller
  always_comb begin
    stat.go       = (in_data.func == FUNC_TICK) && (phase_r != PH_IDLE) &&
                    in_data.link_up && !early;
    stat.done     = (budget_r == '0) || (phase_r == PH_IDLE);
    stat.pend_v   = pend_v_r;
    stat.out_free = out_free;
  end

  // Item handling and burst steps
  always_comb begin
    grid_nxt      = grid_r;
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    pos_nxt       = pos_r;
    next_time_nxt = next_time_r;
    budget_nxt    = budget_r;
    emit          = 1'b0;
    cmd_item      = '0;

    if (cmd.take) begin
      case (in_data.func)
        FUNC_LOAD: begin
          grid_nxt[in_data.row] = in_data.row_bits;
        end
        FUNC_ARM: begin
          if (in_data.link_up) begin
            phase_nxt     = PH_SELECT;
            slot_nxt      = in_data.slot;
            pos_nxt       = '0;
            next_time_nxt = in_data.now_ms;
          end
        end
        FUNC_TICK: begin
          if (phase_r != PH_IDLE && !in_data.link_up) begin
            phase_nxt = PH_IDLE;
          end
          if (stat.go) begin
            budget_nxt = BUDGET_W'(PACKETS_PER_TICK);
          end
        end
        default: begin
        end
      endcase
    end

    if (fire) begin
      case (phase_r)
        PH_SELECT: begin
          emit              = 1'b1;
          cmd_item.kind     = KIND_SELECT;
          cmd_item.sel_slot = slot_r;
          phase_nxt         = PH_CLEAR;
          pos_nxt           = '0;
          budget_nxt        = budget_r - 1'b1;
        end
        PH_CLEAR: begin
          emit           = 1'b1;
          cmd_item.kind  = KIND_STEP;
          cmd_item.track = cur_t;
          cmd_item.step  = cur_s;
          pos_nxt        = pos_r + 1'b1;
          budget_nxt     = budget_r - 1'b1;
          if (pos_nxt[POS_W-1]) begin
            phase_nxt = PH_ACTIVE;
            pos_nxt   = '0;
          end
        end
        PH_ACTIVE: begin
          // Scan the rest of the current row; an empty row costs no budget
          if (hit[4]) begin
            emit            = 1'b1;
            cmd_item.kind   = KIND_STEP;
            cmd_item.track  = cur_t;
            cmd_item.step   = hit[3:0];
            cmd_item.active = 1'b1;
            pos_nxt         = {1'b0, cur_t, hit[3:0]} + 1'b1;
            budget_nxt      = budget_r - 1'b1;
          end else begin
            pos_nxt = {1'b0, cur_t, 4'd0} + POS_W'(STEPS);
          end
          if (pos_nxt[POS_W-1]) begin
            phase_nxt = PH_START;
          end
        end
        PH_START: begin
          emit          = !playing_r;
          cmd_item.kind = KIND_START;
          phase_nxt     = PH_IDLE;
          budget_nxt    = budget_r - 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (cmd.finish) begin
      next_time_nxt = now_r + {24'd0, pacing_r};
    end
  end

  // Hold one command back so the last of a burst can be flagged
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && out_stall;
    if (fire && emit) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = cmd_item;
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
    end else if (cmd.flush && pend_v_r && out_free) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r      <= '{default: '0};
      phase_r     <= PH_IDLE;
      slot_r      <= '0;
      pos_r       <= '0;
      next_time_r <= '0;
      budget_r    <= '0;
      pacing_r    <= PACING_RESET;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      grid_r      <= grid_nxt;
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      pos_r       <= pos_nxt;
      next_time_r <= next_time_nxt;
      budget_r    <= budget_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        pacing_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (cmd.take && stat.go) begin
      now_r     <= in_data.now_ms;
      playing_r <= in_data.playing;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule : ppcs_dp

`default_nettype wire

// ===== dv/pattern_push_command_sequencer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_push_command_sequencer_core_test
// Self-checking bench for the pattern push command sequencer. A built-in
// model of the push (select, 256 clears, set steps, start) predicts every
// command of each tick burst. A checker compares the commands field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module pattern_push_command_sequencer_core_test;
  import ppcs_pkg::*;

  localparam logic [1:0]  FUNC_NONE      = 2'd3;  // unused code, ignored
  localparam int unsigned CELL_COUNT     = TRACKS * STEPS;
  localparam int unsigned ITEM_GOAL      = 480;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // Push model state
  phase_t      ph_m = PH_IDLE;
  logic [3:0]  slot_m = '0;
  int unsigned pos_m = 0;
  logic [31:0] next_m = '0;
  logic [15:0] grid_m [TRACKS];
  logic [7:0]  pacing_m = PACING_RESET;

  out_item_t   pending_cmds [$];
  out_item_t   want_cmd;

  // Run bookkeeping
  bit          idle_on = 1'b1;
  logic [31:0] wall_ms = '0;
  int unsigned items_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned mismatches = 0;
  int unsigned pacing_writes = 0;
  int unsigned arms_taken = 0;
  int unsigned pushes_finished = 0;
  int unsigned pushes_dropped = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_wait = 0;
  int unsigned stall_len;

  pattern_push_command_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Grid rows: mostly empty or sparse, some random, a few full
  function automatic logic [15:0] pick_row_bits();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'h0000;
    if (r < 75) return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
    if (r < 93) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t make_item(input logic [1:0] f, input logic [3:0] r,
                                         input logic [15:0] b, input logic [3:0] sl,
                                         input logic lk, input logic pl,
                                         input logic [31:0] ms);
    in_item_t it;
    it.func     = f;
    it.row      = r;
    it.row_bits = b;
    it.slot     = sl;
    it.link_up  = lk;
    it.playing  = pl;
    it.now_ms   = ms;
    return it;
  endfunction

  // Advance the push model by one accepted item, queue the burst it emits
  task automatic predict_commands(input in_item_t it);
    out_item_t   burst [$];
    out_item_t   c;
    int          budget;
    int unsigned t;
    int unsigned s;
    bit          hit;
    logic [31:0] lag;
    budget = PACKETS_PER_TICK;
    case (it.func)
      FUNC_LOAD: begin
        grid_m[it.row] = it.row_bits;
      end
      FUNC_ARM: begin
        if (it.link_up) begin
          ph_m   = PH_SELECT;
          slot_m = it.slot;
          pos_m  = 0;
          next_m = it.now_ms;
          arms_taken++;
        end
      end
      FUNC_TICK: begin
        lag = it.now_ms - next_m;
        if (ph_m == PH_IDLE) begin
          // nothing to push
        end else if (!it.link_up) begin
          ph_m = PH_IDLE;
          pushes_dropped++;
        end else if (!lag[31]) begin
          while (budget > 0 && ph_m != PH_IDLE) begin
            c = '0;
            case (ph_m)
              PH_SELECT: begin
                c.kind     = KIND_SELECT;
                c.sel_slot = slot_m;
                burst.push_back(c);
                ph_m  = PH_CLEAR;
                pos_m = 0;
                budget--;
              end
              PH_CLEAR: begin
                c.kind  = KIND_STEP;
                c.track = 4'(pos_m >> 4);
                c.step  = 4'(pos_m);
                burst.push_back(c);
                pos_m++;
                budget--;
                if (pos_m >= CELL_COUNT) begin
                  ph_m  = PH_ACTIVE;
                  pos_m = 0;
                end
              end
              PH_ACTIVE: begin
                // scan forward to the next set bit; an empty scan is free
                hit = 1'b0;
                while (pos_m < CELL_COUNT && !hit) begin
                  t = pos_m >> 4;
                  s = pos_m & 15;
                  pos_m++;
                  if (grid_m[t][s]) begin
                    c.kind   = KIND_STEP;
                    c.track  = 4'(t);
                    c.step   = 4'(s);
                    c.active = 1'b1;
                    burst.push_back(c);
                    budget--;
                    hit = 1'b1;
                  end
                end
                if (pos_m >= CELL_COUNT) ph_m = PH_START;
              end
              PH_START: begin
                // start costs budget even when playback already runs
                if (!it.playing) begin
                  c.kind = KIND_START;
                  burst.push_back(c);
                end
                ph_m = PH_IDLE;
                budget--;
                pushes_finished++;
              end
              default: begin
                ph_m = PH_IDLE;
              end
            endcase
          end
          if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
          next_m = it.now_ms + 32'(pacing_m);
          foreach (burst[k]) pending_cmds.push_back(burst[k]);
        end
      end
      default: begin
        // unused function code: drop the item
      end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("error @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("command %0d, %s: got %0d, expected %0d",
                              cmds_checked, name, got, want));
    end
  endtask

  // Present one item after a random gap, hold it until taken, then predict
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_commands(it);
    if (it.func != FUNC_NONE) items_sent++;
  endtask

  // Drop valid, drain all expected commands, then let the block finish a scan
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pacing(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pacing_m = v;
    pacing_writes++;
  endtask

  // One push with random grid edits, early ticks, noise, and maybe a drop
  // or a restart somewhere along the way
  task automatic run_push(input int unsigned max_ticks);
    in_item_t    it;
    int unsigned n;
    int unsigned r;
    int unsigned drop_at;
    int unsigned restart_at;
    drop_at    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
    restart_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0;
    if ($urandom_range(0, 3) == 0) wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else wall_ms = $urandom;
    repeat ($urandom_range(1, 4)) begin
      it = random_item();
      it.func     = FUNC_LOAD;
      it.row_bits = pick_row_bits();
      send_item(it);
    end
    it = random_item();
    it.func    = FUNC_ARM;
    it.link_up = 1'b1;
    it.now_ms  = wall_ms;
    send_item(it);
    n = 0;
    while (ph_m != PH_IDLE && n < max_ticks) begin
      n++;
      it = random_item();
      it.link_up = 1'b1;
      r = $urandom_range(0, 99);
      if (n == drop_at) begin
        it.func    = FUNC_TICK;
        it.link_up = 1'b0;
      end else if (n == restart_at) begin
        it.func   = FUNC_ARM;
        wall_ms   = wall_ms + $urandom_range(0, 3);
        it.now_ms = wall_ms;
      end else if (r < 4) begin
        it.func     = FUNC_LOAD;
        it.row_bits = pick_row_bits();
      end else if (r < 6) begin
        it.func = FUNC_NONE;
      end else if (r < 8) begin
        it.func    = FUNC_ARM;
        it.link_up = 1'b0;
      end else begin
        it.func = FUNC_TICK;
        if (r < 20) begin
          it.now_ms = next_m - $urandom_range(1, 32'(pacing_m) + 1);
        end else begin
          wall_ms   = next_m + $urandom_range(0, 3);
          it.now_ms = wall_ms;
        end
      end
      send_item(it);
    end
    // sometimes tick an idle block
    if ($urandom_range(0, 2) == 0) begin
      it = random_item();
      it.func = FUNC_TICK;
      send_item(it);
    end
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    send_item(make_item(FUNC_LOAD, 4'd0, 16'hFFFF, 4'd0, 1'b1, 1'b0, 32'd0));
    send_item(make_item(FUNC_LOAD, 4'd15, 16'h8001, 4'd15, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_LOAD, 4'd7, 16'h0000, 4'd0, 1'b1, 1'b1, 32'd5));
    send_item(make_item(FUNC_NONE, 4'd15, 16'hFFFF, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF));
    // tick while idle, arm with link down
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_ARM, 4'd0, 16'h0000, 4'd3, 1'b0, 1'b0, 32'd10));
    // arm near the wrap of the time stamp, then early and on-time ticks
    send_item(make_item(FUNC_ARM, 4'd0, 16'h0000, 4'd15, 1'b1, 1'b0, 32'hFFFF_FFFE));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'hFFFF_FFFD));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'hFFFF_FFFE));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b1, 32'd0));
    // link loss drops the push, a later tick does nothing
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b0, 32'd2));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'd4));
    // restart a running push from the select command
    send_item(make_item(FUNC_ARM, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'd100));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'd100));
    send_item(make_item(FUNC_ARM, 4'd0, 16'h0000, 4'd9, 1'b1, 1'b0, 32'd101));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b1, 32'd101));
    // half-range distance: one step is early, one less is on time
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'h8000_0067));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b0, 32'h8000_0066));
    send_item(make_item(FUNC_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b0, 32'h8000_0070));
  endtask

  task automatic test_pacing_sweep();
    logic [7:0] sweep [4];
    sweep = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
    foreach (sweep[k]) begin
      settle();
      idle_on = (k != 0);
      write_pacing(sweep[k]);
      run_push(150);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    while (items_sent < ITEM_GOAL) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        settle();
        r = $urandom_range(0, 9);
        write_pacing(r == 0 ? 8'd0 : r == 1 ? 8'd255 : 8'($urandom_range(0, 12)));
      end
      run_push(150);
    end
  endtask

  // Result side stalls: random bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      sink_wait <= $urandom_range(0, 5);
    end else if (idle_on) begin
      stall_len = pick_gap();
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        sink_wait <= stall_len - 1;
      end
    end
  end

  // Compare each taken command with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected command %h", out_data));
      end else begin
        want_cmd = pending_cmds.pop_front();
        check_field("kind", 32'(out_data.kind), 32'(want_cmd.kind));
        check_field("sel_slot", 32'(out_data.sel_slot), 32'(want_cmd.sel_slot));
        check_field("track", 32'(out_data.track), 32'(want_cmd.track));
        check_field("step", 32'(out_data.step), 32'(want_cmd.step));
        check_field("active", 32'(out_data.active), 32'(want_cmd.active));
        check_field("last", 32'(out_data.last), 32'(want_cmd.last));
      end
      cmds_checked++;
    end
  end

  // Stop a hung run: count cycles in which no item moves anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d commands outstanding",
               quiet_cycles, pending_cmds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (grid_m[k]) grid_m[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_pacing_sweep();
    test_random_traffic();
    settle();
    $display("Sent %0d items, checked %0d commands, %0d pacing writes.",
             items_sent, cmds_checked, pacing_writes);
    $display("Pushes armed %0d, run to the start step %0d, dropped on link loss %0d.",
             arms_taken, pushes_finished, pushes_dropped);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
